[rtl/stlb_pkg.sv]
// ----------------------------------------------------------------------------
// stlb_pkg: shared types and constants for the software managed TLB
// Field widths, mode, fault and register codes, and the reset contents of the
// translation entries.
// ----------------------------------------------------------------------------
package stlb_pkg;

    localparam int ADDR_W    = 16;
    localparam int MODE_W    = 2;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 7;
    localparam int FAULT_W   = 4;
    localparam int PAGE_W    = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [FAULT_W-1:0]   t_fault;
    typedef logic [PAGE_W-1:0]    t_page;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Entry flags, laid out as bits 6:4 of a physical page write beat.
    typedef struct packed {
        logic p;  // privileged
        logic v;  // valid
        logic r;  // read-only
    } t_flags;

    localparam t_mode MODE_TRANSLATE = 2'd0;
    localparam t_mode MODE_WR_PHYS   = 2'd1;
    localparam t_mode MODE_WR_VIRT   = 2'd2;

    localparam t_fault FAULT_NONE      = 4'd0;
    localparam t_fault FAULT_UNALIGNED = 4'd1;
    localparam t_fault FAULT_ITLB_MISS = 4'd2;
    localparam t_fault FAULT_DTLB_MISS = 4'd3;
    localparam t_fault FAULT_ITLB_INV  = 4'd4;
    localparam t_fault FAULT_DTLB_INV  = 4'd5;
    localparam t_fault FAULT_ITLB_PROT = 4'd6;
    localparam t_fault FAULT_DTLB_PROT = 4'd7;
    localparam t_fault FAULT_READONLY  = 4'd8;

    localparam t_cfg_idx CFG_TRANSLATION_ENABLED = 2'd0;
    localparam t_cfg_idx CFG_TLB_KIND            = 2'd1;

    localparam int RESET_ENTRIES = 8;

    // Identity map of pages 0 to 2, page 8 and pages C to F (top quarter).
    localparam t_page RESET_PAGE [RESET_ENTRIES] = '{
        4'h0, 4'h1, 4'h2, 4'h8, 4'hC, 4'hD, 4'hE, 4'hF
    };

    localparam t_flags RESET_FLAGS [RESET_ENTRIES] = '{
        3'b010, 3'b010, 3'b010, 3'b110, 3'b111, 3'b111, 3'b111, 3'b111
    };

    function automatic t_page reset_page(input int unsigned n);
        t_page pg;
        pg = '0;
        if (n < RESET_ENTRIES) begin
            pg = RESET_PAGE[n[2:0]];
        end
        return pg;
    endfunction

    function automatic t_flags reset_flags(input int unsigned n);
        t_flags fl;
        fl = '0;
        if (n < RESET_ENTRIES) begin
            fl = RESET_FLAGS[n[2:0]];
        end
        return fl;
    endfunction

endpackage

[rtl/stlb_in_if.sv]
// ----------------------------------------------------------------------------
// stlb_in_if: request channel of the software managed TLB
// Carries translate and entry write beats with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stlb_in_if import stlb_pkg::*;;
    logic               valid;
    logic               ready;
    t_mode              mode;
    logic [ADDR_W-1:0]  virt_addr;
    logic               is_word;
    logic               write_access;
    logic               user_mode;
    logic [IDX_W-1:0]   entry_index;
    logic [VAL_W-1:0]   entry_value;

    modport source (
        output valid, mode, virt_addr, is_word, write_access, user_mode,
               entry_index, entry_value,
        input  ready
    );

    modport sink (
        input  valid, mode, virt_addr, is_word, write_access, user_mode,
               entry_index, entry_value,
        output ready
    );
endinterface

[rtl/stlb_out_if.sv]
// ----------------------------------------------------------------------------
// stlb_out_if: result channel of the software managed TLB
// Carries the physical address and fault code of each request beat.
// ----------------------------------------------------------------------------
interface stlb_out_if import stlb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  phys_addr;
    t_fault             fault_code;

    modport source (
        output valid, phys_addr, fault_code,
        input  ready
    );

    modport sink (
        input  valid, phys_addr, fault_code,
        output ready
    );
endinterface

[rtl/stlb_cfg_if.sv]
// ----------------------------------------------------------------------------
// stlb_cfg_if: configuration write channel of the software managed TLB
// One beat writes one control register, selected by index.
// ----------------------------------------------------------------------------
interface stlb_cfg_if import stlb_pkg::*;;
    logic       valid;
    logic       ready;
    t_cfg_idx   index;
    logic       data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/software_managed_tlb.sv]
// ----------------------------------------------------------------------------
// software_managed_tlb: fully associative, software loaded TLB
// Request beats on i_in either translate a virtual address or load one entry
// (physical page and flags, or virtual page). Every request beat gives one
// result beat on o_out: physical address and fault code, both zero for
// entry writes and ignored modes. i_cfg writes the translation enable and
// TLB kind registers; it is always ready. The user must see that it is
// written only while idle; the block does not enforce this. Throughput:
// one beat per cycle while o_out does not stall, set by the single stage
// between the request register and the result register, where all entries
// are compared in parallel and entry writes are applied in request order.
// When o_out stalls, the result register holds; the request register still
// takes one more beat, then i_in.ready drops until o_out drains.
// Reset (synchronous, active low) empties both registers, enables
// translation, selects the data TLB kind and loads the entries with the
// boot identity map; no clearing pass is needed.
// ----------------------------------------------------------------------------
module software_managed_tlb import stlb_pkg::*; #(
    parameter int ENTRY_COUNT      = 8,
    parameter int PAGE_OFFSET_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stlb_in_if.sink     i_in,
    stlb_out_if.source  o_out,
    stlb_cfg_if.sink    i_cfg
);

    localparam int VPN_W = ADDR_W - PAGE_OFFSET_BITS;
    localparam int CMP_W = (VPN_W > PAGE_W) ? VPN_W : PAGE_W;
    localparam int SEL_W = $clog2(ENTRY_COUNT);

    // control registers
    logic r_xlate_en;
    logic r_tlb_kind;

    // entries
    t_page  r_vpage [ENTRY_COUNT];
    t_page  r_ppage [ENTRY_COUNT];
    t_flags r_flags [ENTRY_COUNT];

    // request register
    logic               r_s1_valid;
    t_mode              r_s1_mode;
    logic [ADDR_W-1:0]  r_s1_va;
    logic               r_s1_word;
    logic               r_s1_wr;
    logic               r_s1_user;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [VAL_W-1:0]   r_s1_val;

    // result register
    logic               r_o_valid;
    logic [ADDR_W-1:0]  r_o_phys;
    t_fault             r_o_fault;

    logic               out_free;
    logic               s1_move;
    logic               in_acc;
    logic [CMP_W-1:0]   vpn_ext;
    logic [ENTRY_COUNT-1:0] hit;
    logic               found;
    logic [SEL_W-1:0]   sel;
    t_page              hit_pg;
    t_flags             hit_fl;
    logic [ADDR_W-1:0]  n_phys;
    t_fault             n_fault;

    assign out_free   = !r_o_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_o_valid;
    assign o_out.phys_addr  = r_o_phys;
    assign o_out.fault_code = r_o_fault;

    // ---------------- lookup ----------------
    assign vpn_ext = CMP_W'(r_s1_va[ADDR_W-1:PAGE_OFFSET_BITS]);

    always_comb begin
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            hit[i] = (CMP_W'(r_vpage[i]) == vpn_ext);
        end
    end

    // lowest-numbered matching entry wins
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = 1'b1;
                sel   = SEL_W'(i);
            end
        end
    end

    assign hit_pg = r_ppage[sel];
    assign hit_fl = r_flags[sel];

    always_comb begin
        n_phys  = '0;
        n_fault = FAULT_NONE;
        case (r_s1_mode)
            MODE_TRANSLATE: begin
                if (!r_xlate_en) begin
                    n_phys = r_s1_va;
                end else if (r_s1_word && r_s1_va[0]) begin
                    n_fault = FAULT_UNALIGNED;
                end else if (!found) begin
                    n_fault = r_tlb_kind ? FAULT_ITLB_MISS : FAULT_DTLB_MISS;
                end else if (!hit_fl.v) begin
                    n_fault = r_tlb_kind ? FAULT_ITLB_INV : FAULT_DTLB_INV;
                end else if (hit_fl.p && r_s1_user) begin
                    n_fault = r_tlb_kind ? FAULT_ITLB_PROT : FAULT_DTLB_PROT;
                end else if (hit_fl.r && r_s1_wr) begin
                    n_fault = FAULT_READONLY;
                end else begin
                    n_phys = ADDR_W'({hit_pg, r_s1_va[PAGE_OFFSET_BITS-1:0]});
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- entries ----------------
    // Writes land when the beat leaves the request register, so a later
    // translate in the same stream sees them.
    for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_entry
        logic sel_wr;
        assign sel_wr = s1_move && (int'(r_s1_idx) == g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vpage[g] <= reset_page(g);
                r_ppage[g] <= reset_page(g);
                r_flags[g] <= reset_flags(g);
            end else if (sel_wr) begin
                if (r_s1_mode == MODE_WR_PHYS) begin
                    r_ppage[g] <= r_s1_val[PAGE_W-1:0];
                    r_flags[g] <= t_flags'(r_s1_val[VAL_W-1:PAGE_W]);
                end else if (r_s1_mode == MODE_WR_VIRT) begin
                    r_vpage[g] <= r_s1_val[PAGE_W-1:0];
                end
            end
        end
    end

    // ---------------- control and pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xlate_en <= 1'b1;
            r_tlb_kind <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TRANSLATION_ENABLED: r_xlate_en <= i_cfg.data;
                CFG_TLB_KIND:            r_tlb_kind <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mode <= i_in.mode;
            r_s1_va   <= i_in.virt_addr;
            r_s1_word <= i_in.is_word;
            r_s1_wr   <= i_in.write_access;
            r_s1_user <= i_in.user_mode;
            r_s1_idx  <= i_in.entry_index;
            r_s1_val  <= i_in.entry_value;
        end
        if (s1_move) begin
            r_o_phys  <= n_phys;
            r_o_fault <= n_fault;
        end
    end

endmodule

[rtl/stlb_checker.sv]
// ----------------------------------------------------------------------------
// stlb_checker: port level checks for the software managed TLB
// Watches the result channel and reset; bound to the top level below.
// ----------------------------------------------------------------------------
module stlb_checker import stlb_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [ADDR_W-1:0]    i_phys_addr,
    input t_fault               i_fault_code
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_phys_addr) && $stable(i_fault_code))
        else $error("result beat changed while stalled");

    a_fault_zero_pa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_fault_code != FAULT_NONE) |-> (i_phys_addr == '0))
        else $error("faulting beat carries a nonzero address");

    a_fault_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fault_code <= FAULT_READONLY))
        else $error("fault code out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind software_managed_tlb stlb_checker u_stlb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_phys_addr  (o_out.phys_addr),
    .i_fault_code (o_out.fault_code)
);

[verif/tlb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_checker: scoreboard for the software managed TLB
// Watches the request, result and register channels, keeps its own copy of
// the entries and control bits, predicts every result beat and compares it
// field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module tlb_checker import stlb_pkg::*; #(
    parameter int ENTRY_COUNT      = 8,
    parameter int PAGE_OFFSET_BITS = 12
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    stlb_in_if     in_ch,
    stlb_out_if    out_ch,
    stlb_cfg_if    cfg_ch,
    output int     o_fail_count,
    output int     o_pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] phys_addr;
        t_fault            fault_code;
    } t_xlat_result;

    t_page        vpage_tbl [ENTRY_COUNT];
    t_page        ppage_tbl [ENTRY_COUNT];
    t_flags       flag_tbl  [ENTRY_COUNT];
    logic         xlate_en;
    logic         itlb_sel;
    t_xlat_result expected_xlat_q [$];

    task automatic load_boot_map();
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (i < RESET_ENTRIES) begin
                vpage_tbl[i] = RESET_PAGE[i];
                ppage_tbl[i] = RESET_PAGE[i];
                flag_tbl[i]  = RESET_FLAGS[i];
            end else begin
                vpage_tbl[i] = '0;
                ppage_tbl[i] = '0;
                flag_tbl[i]  = '0;
            end
        end
        xlate_en = 1'b1;
        itlb_sel = 1'b0;
    endtask

    // Applies one request beat to the shadow entries and returns its result.
    function automatic t_xlat_result tlb_access(
        input t_mode             mode,
        input logic [ADDR_W-1:0] va,
        input logic              word,
        input logic              wr,
        input logic              user,
        input logic [IDX_W-1:0]  idx,
        input logic [VAL_W-1:0]  val
    );
        t_xlat_result res;
        int           vpn;
        int           hit;
        logic [31:0]  wide;
        res.phys_addr  = '0;
        res.fault_code = FAULT_NONE;
        case (mode)
            MODE_TRANSLATE: begin
                if (!xlate_en) begin
                    res.phys_addr = va;
                end else if (word && va[0]) begin
                    res.fault_code = FAULT_UNALIGNED;
                end else begin
                    vpn = int'(va >> PAGE_OFFSET_BITS);
                    hit = -1;
                    // scan downward so the lowest matching entry wins
                    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
                        if (int'(vpage_tbl[i]) == vpn) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        res.fault_code = itlb_sel ? FAULT_ITLB_MISS : FAULT_DTLB_MISS;
                    end else if (!flag_tbl[hit].v) begin
                        res.fault_code = itlb_sel ? FAULT_ITLB_INV : FAULT_DTLB_INV;
                    end else if (flag_tbl[hit].p && user) begin
                        res.fault_code = itlb_sel ? FAULT_ITLB_PROT : FAULT_DTLB_PROT;
                    end else if (flag_tbl[hit].r && wr) begin
                        res.fault_code = FAULT_READONLY;
                    end else begin
                        wide = (32'(ppage_tbl[hit]) << PAGE_OFFSET_BITS)
                             | (32'(va) & ((32'd1 << PAGE_OFFSET_BITS) - 32'd1));
                        res.phys_addr = wide[ADDR_W-1:0];
                    end
                end
            end
            MODE_WR_PHYS: begin
                if (int'(idx) < ENTRY_COUNT) begin
                    ppage_tbl[idx] = val[PAGE_W-1:0];
                    flag_tbl[idx]  = t_flags'(val[6:4]);
                end
            end
            MODE_WR_VIRT: begin
                if (int'(idx) < ENTRY_COUNT) begin
                    vpage_tbl[idx] = val[PAGE_W-1:0];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_xlat_result want;
        if (!i_rst_n) begin
            load_boot_map();
            expected_xlat_q.delete();
            o_fail_count = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_xlat_q.size() == 0) begin
                    $error("result beat with nothing expected: phys_addr %h fault_code %0d",
                           out_ch.phys_addr, out_ch.fault_code);
                    o_fail_count++;
                end else begin
                    want = expected_xlat_q.pop_front();
                    if (out_ch.phys_addr !== want.phys_addr) begin
                        $error("phys_addr mismatch: expected %h, actual %h",
                               want.phys_addr, out_ch.phys_addr);
                        o_fail_count++;
                    end
                    if (out_ch.fault_code !== want.fault_code) begin
                        $error("fault_code mismatch: expected %0d, actual %0d",
                               want.fault_code, out_ch.fault_code);
                        o_fail_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_TRANSLATION_ENABLED: xlate_en = cfg_ch.data;
                    CFG_TLB_KIND:            itlb_sel = cfg_ch.data;
                    default: begin
                    end
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_xlat_q.push_back(tlb_access(in_ch.mode, in_ch.virt_addr,
                    in_ch.is_word, in_ch.write_access, in_ch.user_mode,
                    in_ch.entry_index, in_ch.entry_value));
            end
        end
        o_pending = expected_xlat_q.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the software managed TLB
// Directed beats over the boot map, entry loads and every fault, then random
// phases under each register setting with random idling on both channels,
// one long result hold-off and a clean final phase. Checking is done by
// tlb_checker.
// ----------------------------------------------------------------------------
module testbench;
    import stlb_pkg::*;

    localparam int    RANDOM_PHASES = 6;
    localparam int    PHASE_ITEMS   = 300;
    localparam int    BURST_ITEMS   = 40;
    localparam int    LONG_HOLD     = 200;
    localparam int    END_WAIT      = 8;
    localparam int    CYCLE_LIMIT   = 400000;
    localparam t_mode MODE_UNUSED   = 2'd3;

    localparam bit PHASE_EN   [RANDOM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam bit PHASE_KIND [RANDOM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    typedef struct packed {
        t_mode             mode;
        logic [ADDR_W-1:0] virt_addr;
        logic              is_word;
        logic              write_access;
        logic              user_mode;
        logic [IDX_W-1:0]  entry_index;
        logic [VAL_W-1:0]  entry_value;
    } t_req;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic tx_idle_en;
    logic rx_idle_en;
    logic rx_hold_req;
    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;

    stlb_in_if  in_ch ();
    stlb_out_if out_ch ();
    stlb_cfg_if cfg_ch ();

    software_managed_tlb u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tlb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic t_req xlate(input logic [ADDR_W-1:0] va, input logic word,
                                   input logic wr, input logic user);
        t_req r;
        r = '0;
        r.mode         = MODE_TRANSLATE;
        r.virt_addr    = va;
        r.is_word      = word;
        r.write_access = wr;
        r.user_mode    = user;
        return r;
    endfunction

    function automatic t_req load(input t_mode mode, input logic [IDX_W-1:0] idx,
                                  input logic [VAL_W-1:0] val);
        t_req r;
        r = '0;
        r.mode        = mode;
        r.entry_index = idx;
        r.entry_value = val;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   pick;
        pick           = $urandom_range(0, 99);
        r.virt_addr    = ADDR_W'($urandom_range(0, 65535));
        r.is_word      = 1'($urandom_range(0, 1));
        r.write_access = 1'($urandom_range(0, 1));
        r.user_mode    = 1'($urandom_range(0, 1));
        r.entry_index  = IDX_W'($urandom_range(0, 7));
        r.entry_value  = VAL_W'($urandom_range(0, 127));
        if (pick < 70) begin
            r.mode = MODE_TRANSLATE;
            // mostly aligned word accesses so lookups get past the alignment check
            if (r.is_word && $urandom_range(0, 3) != 0) begin
                r.virt_addr[0] = 1'b0;
            end
        end else if (pick < 82) begin
            r.mode = MODE_WR_PHYS;
            r.entry_value[5] = ($urandom_range(0, 3) != 0);
        end else if (pick < 94) begin
            r.mode = MODE_WR_VIRT;
        end else begin
            r.mode = MODE_UNUSED;
        end
        return r;
    endfunction

    task automatic send_req(input t_req r);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= r.mode;
        in_ch.virt_addr    <= r.virt_addr;
        in_ch.is_word      <= r.is_word;
        in_ch.write_access <= r.write_access;
        in_ch.user_mode    <= r.user_mode;
        in_ch.entry_index  <= r.entry_index;
        in_ch.entry_value  <= r.entry_value;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        int stall_left;
        hold_left    = 0;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        tx_idle_en         = 1'b1;
        rx_idle_en         = 1'b1;
        rx_hold_req        = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_TRANSLATE;
        in_ch.virt_addr    = '0;
        in_ch.is_word      = 1'b0;
        in_ch.write_access = 1'b0;
        in_ch.user_mode    = 1'b0;
        in_ch.entry_index  = '0;
        in_ch.entry_value  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_TRANSLATION_ENABLED;
        cfg_ch.data        = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // boot map, data TLB
        send_req(xlate(16'h0000, 1'b0, 1'b0, 1'b0));
        send_req(xlate(16'hFFFF, 1'b0, 1'b0, 1'b0));
        send_req(xlate(16'h0001, 1'b1, 1'b0, 1'b0));
        send_req(xlate(16'h3000, 1'b0, 1'b0, 1'b0));
        send_req(xlate(16'h8000, 1'b1, 1'b0, 1'b1));
        send_req(xlate(16'hC002, 1'b0, 1'b1, 1'b0));
        send_req(xlate(16'hDFFE, 1'b1, 1'b0, 1'b0));
        send_req(load(MODE_WR_PHYS, 3'd2, 7'h05));
        send_req(xlate(16'h2ABC, 1'b0, 1'b0, 1'b0));
        send_req(load(MODE_WR_VIRT, 3'd0, 7'h73));
        send_req(xlate(16'h3123, 1'b0, 1'b0, 1'b0));
        // two entries on one page: the lower index must win
        send_req(load(MODE_WR_PHYS, 3'd1, 7'h29));
        send_req(load(MODE_WR_VIRT, 3'd1, 7'h03));
        send_req(xlate(16'h3456, 1'b0, 1'b1, 1'b1));
        send_req('{MODE_UNUSED, 16'hFFFF, 1'b1, 1'b1, 1'b1, 3'd7, 7'h7F});
        send_req(load(MODE_WR_PHYS, 3'd7, 7'h7F));
        send_req(load(MODE_WR_VIRT, 3'd7, 7'h7F));
        send_req(xlate(16'hFFFE, 1'b1, 1'b1, 1'b0));
        drain_results();

        write_reg(CFG_TLB_KIND, 1'b1);
        send_req(xlate(16'h5000, 1'b0, 1'b0, 1'b0));
        send_req(xlate(16'h2000, 1'b0, 1'b0, 1'b0));
        send_req(xlate(16'h8000, 1'b0, 1'b0, 1'b1));
        send_req(xlate(16'hD000, 1'b0, 1'b1, 1'b0));
        drain_results();

        // pass-through skips the alignment check too
        write_reg(CFG_TRANSLATION_ENABLED, 1'b0);
        send_req(xlate(16'hABCD, 1'b1, 1'b1, 1'b1));
        send_req(xlate(16'h0000, 1'b0, 1'b0, 1'b0));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            write_reg(CFG_TRANSLATION_ENABLED, PHASE_EN[ph]);
            write_reg(CFG_TLB_KIND, PHASE_KIND[ph]);
            rx_idle_en = (ph != RANDOM_PHASES - 1);
            if (ph == 0) begin
                rx_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // back-to-back beats during the hold-off so the block backs up
                tx_idle_en = (ph != RANDOM_PHASES - 1) && (ph != 0 || n >= BURST_ITEMS);
                send_req(random_req());
            end
        end

        drain_results();
        repeat (END_WAIT) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/stlb_pkg.sv
rtl/stlb_in_if.sv
rtl/stlb_out_if.sv
rtl/stlb_cfg_if.sv
rtl/software_managed_tlb.sv
rtl/stlb_checker.sv
verif/tlb_checker.sv
verif/testbench.sv
